### rtl/core/rewm_pkg.sv
// Shared types, constants and helpers of the robust EWMA Mahalanobis block.
package rewm_pkg;

    localparam int MAX_DIM  = 8;
    localparam int IDX_W    = 4;
    localparam int DIM_DEF  = 4;
    localparam int FRAC_DEF = 16;
    localparam int VAL_W    = 32;
    localparam int SC_W     = 48;
    localparam int UPD_SH   = 16;

    localparam logic [SC_W-1:0]   MAG47 = 48'h7FFF_FFFF_FFFF;
    localparam logic signed [16:0] W_NEW = 17'sd655;
    localparam logic signed [16:0] W_OLD = 17'sd64881;

    // input commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // scratch write data select
    localparam logic [1:0] WS_COV  = 2'd0;
    localparam logic [1:0] WS_SMP  = 2'd1;
    localparam logic [1:0] WS_DIFF = 2'd2;
    localparam logic [1:0] WS_QUOT = 2'd3;

    // multiplier first operand select
    localparam logic [1:0] MS_F   = 2'd0;
    localparam logic [1:0] MS_OPA = 2'd1;
    localparam logic [1:0] MS_SMP = 2'd2;

    // divider operand select
    localparam logic DS_ELIM = 1'b0;
    localparam logic DS_BACK = 1'b1;

    typedef struct packed {
        logic             ref_we;
        logic             smp_we;
        logic             clr_run;
        logic             cov_rd;
        logic             work_cp;
        logic             work_upd;
        logic             sc_rd;
        logic             sc_we;
        logic [1:0]       sc_wsel;
        logic             piv_ld;
        logic             set_sing;
        logic             f_ld;
        logic             acc_ld;
        logic             acc_sub;
        logic             opa_ld;
        logic             d2_add;
        logic             out_ld;
        logic             ya_ld;
        logic             outer_ld;
        logic             mix_ld;
        logic             mul_start;
        logic [1:0]       mul_sel;
        logic             div_start;
        logic             div_sel;
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
    } dp_cmd_t;

    typedef struct packed {
        logic piv_bad;
        logic mul_done;
        logic div_done;
        logic out_busy;
    } dp_sts_t;

    // clamp a difference to +-(2^47-1)
    function automatic logic signed [SC_W-1:0] sat47(input logic signed [SC_W:0] v);
        logic signed [SC_W:0] hi;
        logic signed [SC_W:0] lo;
        hi = $signed({1'b0, MAG47});
        lo = -hi;
        if (v > hi) begin
            return $signed(MAG47);
        end else if (v < lo) begin
            return -$signed(MAG47);
        end
        return v[SC_W-1:0];
    endfunction

endpackage

### rtl/core/rewm_mul.sv
// Signed fixed-point multiplier built from four 24x24 partial products.
module rewm_mul #(
    parameter int FRAC_BITS = rewm_pkg::FRAC_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [rewm_pkg::SC_W-1:0]   a,
    input  logic signed [rewm_pkg::SC_W-1:0]   b,
    output logic signed [rewm_pkg::SC_W-1:0]   res,
    output logic                               done
);
    import rewm_pkg::*;

    localparam int HW = SC_W / 2;

    logic [SC_W-1:0]   ma_reg, mb_reg;
    logic              neg_reg;
    logic [2*SC_W-1:0] prod_reg;
    logic [1:0]        cnt_reg;
    logic              busy_reg, done_reg;

    logic [HW-1:0]     pa, pb;
    logic [SC_W-1:0]   pp;
    logic [2*SC_W-1:0] pp_sh;
    logic              sat;
    logic [SC_W-1:0]   rmag;

    always_comb begin
        unique case (cnt_reg)
            2'd0: begin pa = ma_reg[SC_W-1:HW]; pb = mb_reg[HW-1:0]; end
            2'd1: begin pa = ma_reg[HW-1:0];    pb = mb_reg[SC_W-1:HW]; end
            2'd2: begin pa = ma_reg[HW-1:0];    pb = mb_reg[HW-1:0]; end
            default: begin pa = ma_reg[SC_W-1:HW]; pb = mb_reg[SC_W-1:HW]; end
        endcase
        pp = pa * pb;
        unique case (cnt_reg)
            2'd0, 2'd1: pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
            2'd2:       pp_sh = {{SC_W{1'b0}}, pp};
            default:    pp_sh = {pp, {SC_W{1'b0}}};
        endcase
    end

    // truncate toward zero, saturate at 2^47-1
    assign sat  = |prod_reg[2*SC_W-1:47+FRAC_BITS];
    assign rmag = sat ? MAG47 : prod_reg[47+FRAC_BITS:FRAC_BITS];
    assign res  = neg_reg ? -$signed(rmag) : $signed(rmag);
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg   <= a[SC_W-1] ? SC_W'(-a) : SC_W'(a);
            mb_reg   <= b[SC_W-1] ? SC_W'(-b) : SC_W'(b);
            neg_reg  <= a[SC_W-1] ^ b[SC_W-1];
            prod_reg <= '0;
        end else if (busy_reg) begin
            prod_reg <= prod_reg + pp_sh;
        end
    end

endmodule

### rtl/core/rewm_div.sv
// Restoring divider, one quotient bit per cycle, fixed-point quotient.
module rewm_div #(
    parameter int FRAC_BITS = rewm_pkg::FRAC_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [rewm_pkg::SC_W-1:0]   num,
    input  logic        [rewm_pkg::SC_W-1:0]   den,
    output logic signed [rewm_pkg::SC_W-1:0]   res,
    output logic                               done
);
    import rewm_pkg::*;

    localparam int NB = SC_W + FRAC_BITS;
    localparam int CW = $clog2(NB);

    logic [NB-1:0]   dvd_reg;
    logic [SC_W:0]   rem_reg;
    logic [SC_W-1:0] den_reg;
    logic [46:0]     q_reg;
    logic            sat_reg, neg_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg, done_reg;

    logic [SC_W:0]   rn;
    logic            ge;
    logic [SC_W-1:0] qmag;

    assign rn   = {rem_reg[SC_W-1:0], dvd_reg[NB-1]};
    assign ge   = rn >= {1'b0, den_reg};
    assign qmag = sat_reg ? MAG47 : {1'b0, q_reg};
    assign res  = neg_reg ? -$signed(qmag) : $signed(qmag);
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NB - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {(num[SC_W-1] ? SC_W'(-num) : SC_W'(num)), {FRAC_BITS{1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
            neg_reg <= num[SC_W-1];
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[NB-2:0], 1'b0};
            rem_reg <= ge ? rn - {1'b0, den_reg} : rn;
            q_reg   <= {q_reg[45:0], ge};
            // a quotient bit at weight 2^47 or above overflows
            if (ge && cnt_reg >= CW'(47)) begin
                sat_reg <= 1'b1;
            end
        end
    end

endmodule

### rtl/core/rewm_dp.sv
// Datapath: covariance memories, solve scratch, arithmetic units, result register.
module rewm_dp #(
    parameter int DIM       = rewm_pkg::DIM_DEF,
    parameter int FRAC_BITS = rewm_pkg::FRAC_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rewm_pkg::dp_cmd_t                 cmd,
    output rewm_pkg::dp_sts_t                 sts,
    input  logic [2:0]                        in_row,
    input  logic [2:0]                        in_col,
    input  logic signed [rewm_pkg::VAL_W-1:0] in_value,
    input  logic signed [rewm_pkg::VAL_W-1:0] in_score,
    input  logic                              cfg_wr_en,
    input  logic [rewm_pkg::VAL_W-1:0]        cfg_wr_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [47:0]                       out_distance,
    output logic                              out_singular
);
    import rewm_pkg::*;

    localparam int NCOV = DIM * DIM;
    localparam int CA_W = (NCOV > 1) ? $clog2(NCOV) : 1;
    localparam int NSC  = DIM * (DIM + 1);
    localparam int SA_W = $clog2(NSC);
    localparam int SM_W = (DIM > 1) ? $clog2(DIM) : 1;

    // covariance memories with per-entry valid bits (reset reads as zero)
    logic signed [VAL_W-1:0] ref_mem  [NCOV];
    logic signed [VAL_W-1:0] work_mem [NCOV];
    logic [NCOV-1:0]         ref_vld_reg, work_vld_reg;
    logic signed [VAL_W-1:0] ref_q_reg, work_q_reg;
    logic                    ref_qv_reg, work_qv_reg;
    logic signed [VAL_W-1:0] ref_val, work_val;

    logic signed [SC_W-1:0]  sc_mem [NSC];
    logic signed [SC_W-1:0]  sc_q_reg;
    logic signed [VAL_W-1:0] smp_mem [DIM];
    logic signed [VAL_W-1:0] smp_rd;

    logic [CA_W-1:0] cov_addr, in_addr;
    logic [SA_W-1:0] sc_addr;
    logic [SM_W-1:0] smp_idx;

    logic signed [VAL_W-1:0] lim_reg, score_reg;
    logic signed [SC_W-1:0]  piv_reg, f_reg, acc_reg, opa_reg;
    logic signed [SC_W+2:0]  d2_reg;
    logic                    sing_reg;
    logic signed [VAL_W-1:0] ya_reg;
    logic signed [2*VAL_W-1:0] outer_reg;
    logic signed [48:0]      pn_reg, po_reg;
    logic                    out_valid_reg, out_sing_reg;
    logic [47:0]             out_dist_reg;

    logic signed [SC_W-1:0]  mul_a, mul_res, div_num, div_res;
    logic [SC_W-1:0]         div_den;
    logic                    mul_done, div_done;
    logic signed [SC_W-1:0]  sc_wdata;
    logic signed [VAL_W-1:0] work_wdata;
    logic signed [2*VAL_W-1:0] outer_sh;
    logic signed [VAL_W-1:0] mix_m;
    logic signed [49:0]      upd_sum;
    logic [47:0]             dist_clamped;

    assign cov_addr = CA_W'(int'(cmd.ra) * DIM + int'(cmd.rb));
    assign in_addr  = CA_W'(int'(in_row) * DIM + int'(in_col));
    assign sc_addr  = SA_W'(int'(cmd.ra) * (DIM + 1) + int'(cmd.rb));
    assign smp_idx  = cmd.ra[SM_W-1:0];
    assign smp_rd   = smp_mem[smp_idx];

    assign ref_val  = ref_qv_reg  ? ref_q_reg  : '0;
    assign work_val = work_qv_reg ? work_q_reg : '0;

    always_comb begin
        unique case (cmd.sc_wsel)
            WS_COV:  sc_wdata = SC_W'(work_val);
            WS_SMP:  sc_wdata = SC_W'(smp_rd);
            WS_DIFF: sc_wdata = sat47((SC_W+1)'(sc_q_reg) - (SC_W+1)'(mul_res));
            default: sc_wdata = div_res;
        endcase
        unique case (cmd.mul_sel)
            MS_F:    mul_a = f_reg;
            MS_OPA:  mul_a = opa_reg;
            default: mul_a = SC_W'(smp_rd);
        endcase
        if (cmd.div_sel == DS_ELIM) begin
            div_num = sc_q_reg;
            div_den = piv_reg;
        end else begin
            div_num = acc_reg;
            div_den = sc_q_reg;
        end
    end

    // outer-product entry (floor shift, clamp to 32-bit signed) when score is below lim, else the reference entry
    always_comb begin
        outer_sh = outer_reg >>> FRAC_BITS;
        if (score_reg < lim_reg) begin
            if (outer_sh > 64'sh7FFF_FFFF) begin
                mix_m = 32'sh7FFF_FFFF;
            end else if (outer_sh < -64'sh8000_0000) begin
                mix_m = -32'sh8000_0000;
            end else begin
                mix_m = outer_sh[VAL_W-1:0];
            end
        end else begin
            mix_m = ref_val;
        end
    end

    assign upd_sum    = 50'(pn_reg) + 50'(po_reg);
    assign work_wdata = cmd.work_cp ? ref_val : VAL_W'(upd_sum >>> UPD_SH);

    always_comb begin
        if (d2_reg < 0) begin
            dist_clamped = '0;
        end else if (|d2_reg[SC_W+1:SC_W]) begin
            dist_clamped = '1;
        end else begin
            dist_clamped = d2_reg[47:0];
        end
    end

    rewm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (sc_q_reg),
        .res     (mul_res),
        .done    (mul_done)
    );

    rewm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res),
        .done    (div_done)
    );

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.ref_we) begin
            ref_mem[in_addr] <= in_value;
        end
        if (cmd.work_cp || cmd.work_upd) begin
            work_mem[cov_addr] <= work_wdata;
        end
        if (cmd.cov_rd) begin
            ref_q_reg  <= ref_mem[cov_addr];
            work_q_reg <= work_mem[cov_addr];
            ref_qv_reg  <= ref_vld_reg[cov_addr];
            work_qv_reg <= work_vld_reg[cov_addr];
        end
        if (cmd.sc_we) begin
            sc_mem[sc_addr] <= sc_wdata;
        end
        if (cmd.sc_rd) begin
            sc_q_reg <= sc_mem[sc_addr];
        end
        if (cmd.smp_we) begin
            smp_mem[in_col[SM_W-1:0]] <= in_value;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_vld_reg   <= '0;
            work_vld_reg  <= '0;
            lim_reg       <= '0;
            out_valid_reg <= 1'b0;
            sing_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                lim_reg <= cfg_wr_data;
            end
            if (cmd.ref_we) begin
                ref_vld_reg[in_addr] <= 1'b1;
            end
            if (cmd.work_cp || cmd.work_upd) begin
                work_vld_reg[cov_addr] <= 1'b1;
            end
            if (cmd.clr_run) begin
                sing_reg <= 1'b0;
            end else if (cmd.set_sing) begin
                sing_reg <= 1'b1;
            end
            if (cmd.out_ld) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.smp_we) begin
            score_reg <= in_score;
        end
        if (cmd.piv_ld) begin
            piv_reg <= sc_q_reg;
        end
        if (cmd.f_ld) begin
            f_reg <= div_res;
        end
        if (cmd.acc_ld) begin
            acc_reg <= sc_q_reg;
        end else if (cmd.acc_sub) begin
            acc_reg <= sat47((SC_W+1)'(acc_reg) - (SC_W+1)'(mul_res));
        end
        if (cmd.opa_ld) begin
            opa_reg <= sc_q_reg;
        end
        if (cmd.clr_run) begin
            d2_reg <= '0;
        end else if (cmd.d2_add) begin
            d2_reg <= d2_reg + (SC_W+3)'(mul_res);
        end
        if (cmd.ya_ld) begin
            ya_reg <= smp_rd;
        end
        if (cmd.outer_ld) begin
            outer_reg <= ya_reg * smp_rd;
        end
        if (cmd.mix_ld) begin
            pn_reg <= W_NEW * mix_m;
            po_reg <= W_OLD * work_val;
        end
        if (cmd.out_ld) begin
            out_dist_reg <= sing_reg ? '0 : dist_clamped;
            out_sing_reg <= sing_reg;
        end
    end

    assign sts.piv_bad  = sc_q_reg <= 0;
    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign out_distance = out_dist_reg;
    assign out_singular = out_sing_reg;

endmodule

### rtl/core/rewm_ctrl.sv
// Sequencer: command decode, copy, elimination, back substitution and update loops.
module rewm_ctrl #(
    parameter int DIM = rewm_pkg::DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_cmd,
    input  logic [2:0]         in_row,
    input  logic [2:0]         in_col,
    input  rewm_pkg::dp_sts_t  sts,
    output rewm_pkg::dp_cmd_t  cmd
);
    import rewm_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_C_RD  = 5'd1;
    localparam logic [4:0] S_C_WR  = 5'd2;
    localparam logic [4:0] S_L_RD  = 5'd3;
    localparam logic [4:0] S_L_WR  = 5'd4;
    localparam logic [4:0] S_K_RD  = 5'd5;
    localparam logic [4:0] S_K_CHK = 5'd6;
    localparam logic [4:0] S_I_RD  = 5'd7;
    localparam logic [4:0] S_I_DIV = 5'd8;
    localparam logic [4:0] S_I_DW  = 5'd9;
    localparam logic [4:0] S_J_RDK = 5'd10;
    localparam logic [4:0] S_J_MUL = 5'd11;
    localparam logic [4:0] S_J_MW  = 5'd12;
    localparam logic [4:0] S_J_RDI = 5'd13;
    localparam logic [4:0] S_J_WR  = 5'd14;
    localparam logic [4:0] S_B_RD  = 5'd15;
    localparam logic [4:0] S_B_LD  = 5'd16;
    localparam logic [4:0] S_B_RA  = 5'd17;
    localparam logic [4:0] S_B_LA  = 5'd18;
    localparam logic [4:0] S_B_MUL = 5'd19;
    localparam logic [4:0] S_B_MW  = 5'd20;
    localparam logic [4:0] S_B_RDD = 5'd21;
    localparam logic [4:0] S_B_DIV = 5'd22;
    localparam logic [4:0] S_B_DW  = 5'd23;
    localparam logic [4:0] S_D_RD  = 5'd24;
    localparam logic [4:0] S_D_MUL = 5'd25;
    localparam logic [4:0] S_D_MW  = 5'd26;
    localparam logic [4:0] S_EMIT  = 5'd27;
    localparam logic [4:0] S_U_RD  = 5'd28;
    localparam logic [4:0] S_U_M1  = 5'd29;
    localparam logic [4:0] S_U_M2  = 5'd30;
    localparam logic [4:0] S_U_WR  = 5'd31;

    localparam logic [IDX_W-1:0] DL  = IDX_W'(DIM);
    localparam logic [IDX_W-1:0] DM1 = IDX_W'(DIM - 1);
    localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

    logic [4:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic             row_ok, col_ok;

    assign row_ok   = {1'b0, in_row} < DL;
    assign col_ok   = {1'b0, in_col} < DL;
    assign in_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.ra     = i_reg;
        cmd.rb     = j_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    priority if (in_cmd == CMD_LOAD) begin
                        cmd.ref_we = row_ok && col_ok;
                    end else if (in_cmd == CMD_SAMPLE) begin
                        cmd.smp_we = col_ok;
                        if ({1'b0, in_col} == DM1) begin
                            cmd.clr_run = 1'b1;
                            i_next      = '0;
                            j_next      = '0;
                            state_next  = S_L_RD;
                        end
                    end else if (in_cmd == CMD_RESTART) begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = S_C_RD;
                    end else begin
                        // unused command: drop
                        state_next = S_IDLE;
                    end
                end
            end
            S_C_RD: begin
                cmd.cov_rd = 1'b1;
                state_next = S_C_WR;
            end
            S_C_WR: begin
                cmd.work_cp = 1'b1;
                state_next  = S_C_RD;
                if (j_reg == DM1) begin
                    j_next = '0;
                    i_next = i_reg + ONE;
                    if (i_reg == DM1) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    j_next = j_reg + ONE;
                end
            end
            S_L_RD: begin
                cmd.cov_rd = j_reg != DL;
                state_next = S_L_WR;
            end
            S_L_WR: begin
                cmd.sc_we   = 1'b1;
                cmd.sc_wsel = (j_reg == DL) ? WS_SMP : WS_COV;
                state_next  = S_L_RD;
                if (j_reg == DL) begin
                    j_next = '0;
                    i_next = i_reg + ONE;
                    if (i_reg == DM1) begin
                        k_next     = '0;
                        state_next = S_K_RD;
                    end
                end else begin
                    j_next = j_reg + ONE;
                end
            end
            S_K_RD: begin
                cmd.sc_rd  = 1'b1;
                cmd.ra     = k_reg;
                cmd.rb     = k_reg;
                state_next = S_K_CHK;
            end
            S_K_CHK: begin
                cmd.piv_ld = 1'b1;
                if (sts.piv_bad) begin
                    cmd.set_sing = 1'b1;
                    state_next   = S_EMIT;
                end else if (k_reg == DM1) begin
                    i_next     = DM1;
                    state_next = S_B_RD;
                end else begin
                    i_next     = k_reg + ONE;
                    state_next = S_I_RD;
                end
            end
            S_I_RD: begin
                cmd.sc_rd  = 1'b1;
                cmd.rb     = k_reg;
                state_next = S_I_DIV;
            end
            S_I_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_ELIM;
                state_next    = S_I_DW;
            end
            S_I_DW: begin
                if (sts.div_done) begin
                    cmd.f_ld   = 1'b1;
                    j_next     = k_reg;
                    state_next = S_J_RDK;
                end
            end
            S_J_RDK: begin
                cmd.sc_rd  = 1'b1;
                cmd.ra     = k_reg;
                state_next = S_J_MUL;
            end
            S_J_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_F;
                state_next    = S_J_MW;
            end
            S_J_MW: begin
                if (sts.mul_done) begin
                    state_next = S_J_RDI;
                end
            end
            S_J_RDI: begin
                cmd.sc_rd  = 1'b1;
                state_next = S_J_WR;
            end
            S_J_WR: begin
                cmd.sc_we   = 1'b1;
                cmd.sc_wsel = WS_DIFF;
                if (j_reg == DL) begin
                    if (i_reg == DM1) begin
                        k_next     = k_reg + ONE;
                        state_next = S_K_RD;
                    end else begin
                        i_next     = i_reg + ONE;
                        state_next = S_I_RD;
                    end
                end else begin
                    j_next     = j_reg + ONE;
                    state_next = S_J_RDK;
                end
            end
            S_B_RD: begin
                cmd.sc_rd  = 1'b1;
                cmd.rb     = DL;
                state_next = S_B_LD;
            end
            S_B_LD: begin
                cmd.acc_ld = 1'b1;
                j_next     = i_reg + ONE;
                state_next = (i_reg == DM1) ? S_B_RDD : S_B_RA;
            end
            S_B_RA: begin
                cmd.sc_rd  = 1'b1;
                state_next = S_B_LA;
            end
            S_B_LA: begin
                cmd.opa_ld = 1'b1;
                cmd.sc_rd  = 1'b1;
                cmd.ra     = j_reg;
                cmd.rb     = DL;
                state_next = S_B_MUL;
            end
            S_B_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_OPA;
                state_next    = S_B_MW;
            end
            S_B_MW: begin
                if (sts.mul_done) begin
                    cmd.acc_sub = 1'b1;
                    if (j_reg == DM1) begin
                        state_next = S_B_RDD;
                    end else begin
                        j_next     = j_reg + ONE;
                        state_next = S_B_RA;
                    end
                end
            end
            S_B_RDD: begin
                cmd.sc_rd  = 1'b1;
                cmd.rb     = i_reg;
                state_next = S_B_DIV;
            end
            S_B_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_BACK;
                state_next    = S_B_DW;
            end
            S_B_DW: begin
                cmd.div_sel = DS_BACK;
                cmd.rb      = DL;
                if (sts.div_done) begin
                    cmd.sc_we   = 1'b1;
                    cmd.sc_wsel = WS_QUOT;
                    if (i_reg == '0) begin
                        state_next = S_D_RD;
                    end else begin
                        i_next     = i_reg - ONE;
                        state_next = S_B_RD;
                    end
                end
            end
            S_D_RD: begin
                cmd.sc_rd  = 1'b1;
                cmd.rb     = DL;
                state_next = S_D_MUL;
            end
            S_D_MUL: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SMP;
                state_next    = S_D_MW;
            end
            S_D_MW: begin
                if (sts.mul_done) begin
                    cmd.d2_add = 1'b1;
                    if (i_reg == DM1) begin
                        state_next = S_EMIT;
                    end else begin
                        i_next     = i_reg + ONE;
                        state_next = S_D_RD;
                    end
                end
            end
            S_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.out_ld = 1'b1;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_U_RD;
                end
            end
            S_U_RD: begin
                cmd.cov_rd = 1'b1;
                cmd.ya_ld  = 1'b1;
                state_next = S_U_M1;
            end
            S_U_M1: begin
                cmd.outer_ld = 1'b1;
                cmd.ra       = j_reg;
                state_next   = S_U_M2;
            end
            S_U_M2: begin
                cmd.mix_ld = 1'b1;
                state_next = S_U_WR;
            end
            default: begin
                cmd.work_upd = 1'b1;
                state_next   = S_U_RD;
                if (j_reg == DM1) begin
                    j_next = '0;
                    i_next = i_reg + ONE;
                    if (i_reg == DM1) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    j_next = j_reg + ONE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

### rtl/core/robust_ewma_mahalanobis.sv
// Top level of the robust EWMA covariance tracker with Mahalanobis distance.
//
// Input stream (s_*): one request per item. s_tuser carries the command:
// load a reference covariance entry, write one sample element, or restart
// (copy reference into the working covariance). Loads and sample elements
// other than the last leave the sequencer idle. A restart sweeps the matrix.
// The last sample element of a row starts the solve: copy into scratch,
// elimination and back substitution, where every division runs in the serial
// divider (one quotient bit per cycle) and every product in the four-step
// multiplier, then the distance sum and the covariance update.
// Result stream (m_*): one request per row, distance in m_tdata and the
// singular flag in m_tuser. The result sits in an output register; the next
// items are accepted while it waits, and a row that finishes while the
// previous result is still stalled holds until m_tready frees the register.
// Reset clears both covariances, lim and all control state.
module robust_ewma_mahalanobis #(
    parameter int DIM       = rewm_pkg::DIM_DEF,
    parameter int FRAC_BITS = rewm_pkg::FRAC_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_row[2:0], entry_col[5:3], value[37:6], outlier_score[69:38], zero pad
    input  logic [71:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // distance[47:0]
    output logic [47:0] m_tdata,
    // singular[0]
    output logic [0:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    import rewm_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;
    logic    in_ready;
    logic    out_singular;

    // advance the sequencer only on an accepted request
    rewm_ctrl #(.DIM(DIM)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (in_ready),
        .in_cmd   (s_tuser),
        .in_row   (s_tdata[2:0]),
        .in_col   (s_tdata[5:3]),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    rewm_dp #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (dp_cmd),
        .sts          (dp_sts),
        .in_row       (s_tdata[2:0]),
        .in_col       (s_tdata[5:3]),
        .in_value     (s_tdata[37:6]),
        .in_score     (s_tdata[69:38]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_distance (m_tdata),
        .out_singular (out_singular)
    );

    assign s_tready   = in_ready;
    assign m_tuser[0] = out_singular;

endmodule

### tb/tb_robust_ewma_mahalanobis.sv
// Self-checking testbench for the robust EWMA Mahalanobis distance block.
module tb_robust_ewma_mahalanobis;
    timeunit 1ns;
    timeprecision 1ps;
    import rewm_pkg::*;

    localparam int NDIM = DIM_DEF;
    localparam int FB = FRAC_DEF;
    localparam longint SATV = 64'sh7FFF_FFFF_FFFF;
    localparam int WDOG_LIMIT = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    robust_ewma_mahalanobis dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    typedef struct packed {
        logic [47:0] distance;
        logic        singular;
    } dist_res_t;

    // predictor state
    longint lim_q;
    longint ref_m[8][8];
    longint work_m[8][8];
    longint smp[8];
    dist_res_t pending_dist[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    int idle_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic longint clamp47(input longint v);
        if (v > SATV) return SATV;
        if (v < -SATV) return -SATV;
        return v;
    endfunction

    // truncating fixed-point product, saturated
    function automatic longint qmul(input longint a, input longint b);
        logic [95:0] p;
        logic [95:0] r;
        logic [47:0] ma, mb;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 48'(-a) : 48'(a);
        mb = (b < 0) ? 48'(b < 0 ? -b : b) : 48'(b);
        p = 96'(ma) * 96'(mb);
        r = p >> FB;
        if (r > 96'(SATV)) r = 96'(SATV);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // truncating fixed-point quotient with positive divisor, saturated
    function automatic longint qdiv(input longint n, input longint d);
        logic [95:0] m;
        logic [95:0] q;
        m = 96'((n < 0) ? -n : n) << FB;
        q = m / 96'(d);
        if (q > 96'(SATV)) q = 96'(SATV);
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint floor_shr(input longint v, input int sh);
        return v >>> sh;
    endfunction

    function automatic dist_res_t solve_row(input longint score);
        longint a[8][9];
        longint x, piv, f, d2, m;
        bit sing, admit;
        dist_res_t r;
        sing = 1'b0;
        d2 = 0;
        admit = score < lim_q;
        for (int i = 0; i < NDIM; i++) begin
            for (int j = 0; j < NDIM; j++) a[i][j] = work_m[i][j];
            a[i][NDIM] = smp[i];
        end
        for (int k = 0; k < NDIM && !sing; k++) begin
            piv = a[k][k];
            if (piv <= 0) begin
                sing = 1'b1;
            end else begin
                for (int i = k + 1; i < NDIM; i++) begin
                    f = qdiv(a[i][k], piv);
                    for (int j = k; j <= NDIM; j++) a[i][j] = clamp47(a[i][j] - qmul(f, a[k][j]));
                end
            end
        end
        if (!sing) begin
            for (int i = NDIM - 1; i >= 0; i--) begin
                x = a[i][NDIM];
                for (int j = i + 1; j < NDIM; j++) x = clamp47(x - qmul(a[i][j], a[j][NDIM]));
                a[i][NDIM] = qdiv(x, a[i][i]);
            end
            for (int i = 0; i < NDIM; i++) d2 += qmul(smp[i], a[i][NDIM]);
            if (d2 < 0) d2 = 0;
            if (d2 > 64'hFFFF_FFFF_FFFF) d2 = 64'hFFFF_FFFF_FFFF;
        end
        r.distance = sing ? 48'd0 : 48'(d2);
        r.singular = sing;
        // fold the row into the working covariance
        for (int i = 0; i < NDIM; i++) begin
            for (int j = 0; j < NDIM; j++) begin
                if (admit) begin
                    m = floor_shr(smp[i] * smp[j], FB);
                    if (m > 64'sd2147483647) m = 64'sd2147483647;
                    if (m < -64'sd2147483648) m = -64'sd2147483648;
                end else begin
                    m = ref_m[i][j];
                end
                work_m[i][j] = floor_shr(655 * m + 64881 * work_m[i][j], 16);
            end
        end
        return r;
    endfunction

    function automatic void predict_request(input logic [1:0] cmd, input int row, input int col,
                                            input logic [31:0] val, input logic [31:0] score);
        if (cmd == CMD_LOAD) begin
            if (row < NDIM && col < NDIM) ref_m[row][col] = longint'($signed(val));
        end else if (cmd == CMD_RESTART) begin
            work_m = ref_m;
        end else if (cmd == CMD_SAMPLE && col < NDIM) begin
            smp[col] = longint'($signed(val));
            if (col == NDIM - 1) pending_dist.push_back(solve_row(longint'($signed(score))));
        end
    endfunction

    // send one request, holding it until accepted; valid stays up for the next one
    task automatic send_request(input logic [1:0] cmd, input int row, input int col,
                                input logic [31:0] val, input logic [31:0] score);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, score, val, 3'(col), 3'(row)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(cmd, row, col, val, score);
    endtask

    // drop valid and wait until every result is out and the block is idle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_dist.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_lim(input logic [31:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        lim_q = longint'($signed(v));
    endtask

    // receiver: random stall and long hold-off
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dist.size() == 0) begin
                report_mismatch("unexpected distance", m_tdata, 0);
            end else begin
                if (m_tdata !== pending_dist[0].distance)
                    report_mismatch("distance", m_tdata, pending_dist[0].distance);
                if (m_tuser[0] !== pending_dist[0].singular)
                    report_mismatch("singular", m_tuser[0], pending_dist[0].singular);
                void'(pending_dist.pop_front());
            end
        end
    end

    // watchdog on cycles without any accepted request or delivered result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(32'h0003_0000);
            default: return $urandom;
        endcase
    endfunction

    // load a well-conditioned diagonal-dominant reference and restart
    task automatic load_spd_ref();
        logic [31:0] v;
        for (int r = 0; r < NDIM; r++) begin
            for (int c = 0; c < NDIM; c++) begin
                if (r == c) v = 32'h0001_0000 + $urandom_range(32'h0004_0000);
                else v = $signed($urandom_range(32'h0000_4000)) - 32'sh2000;
                send_request(CMD_LOAD, r, c, v, $urandom);
            end
        end
        send_request(CMD_RESTART, $urandom_range(7), $urandom_range(7), $urandom, $urandom);
    endtask

    task automatic send_row(input bit wild);
        logic [31:0] v;
        for (int c = 0; c < NDIM; c++) begin
            v = wild ? rand_word() : 32'($signed($urandom_range(32'h0004_0000)) - 32'sh2_0000);
            send_request(CMD_SAMPLE, $urandom_range(7), c, v, rand_word());
        end
    endtask

    task automatic test_directed();
        // row before any restart: zero working covariance, singular
        send_row(1'b0);
        // ignored requests: out-of-range index and unused command
        send_request(CMD_LOAD, 7, 0, 32'h7FFF_FFFF, '1);
        send_request(CMD_LOAD, 0, 7, 32'h8000_0000, '0);
        send_request(CMD_SAMPLE, 0, 7, 32'h1234_5678, '1);
        send_request(2'd3, 7, 7, '1, '1);
        load_spd_ref();
        send_request(CMD_SAMPLE, 7, 0, 32'h7FFF_FFFF, '0);
        send_request(CMD_SAMPLE, 0, 1, 32'h8000_0000, '0);
        send_request(CMD_SAMPLE, 0, 2, 32'h7FFF_FFFF, '0);
        send_request(CMD_SAMPLE, 0, 3, 32'h8000_0000, 32'h8000_0000);
        send_row(1'b0);
        // nonpositive pivot in the reference
        send_request(CMD_LOAD, 0, 0, 32'hFFFF_0000, '0);
        send_request(CMD_RESTART, 0, 0, '0, '0);
        send_row(1'b0);
    endtask

    task automatic test_random(input int rows);
        for (int n = 0; n < rows; n++) begin
            case ($urandom_range(19))
                0: load_spd_ref();
                1: send_request(CMD_LOAD, $urandom_range(7), $urandom_range(7), rand_word(),
                                $urandom);
                2: send_request(2'd3, $urandom_range(7), $urandom_range(7), $urandom, $urandom);
                3: send_row(1'b1);
                default: send_row(1'b0);
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 6000;
        test_random(6);
        wait_drained();
        test_random(4);
    endtask

    initial begin
        lim_q = 0;
        foreach (ref_m[i, j]) begin
            ref_m[i][j] = 0;
            work_m[i][j] = 0;
        end
        foreach (smp[i]) smp[i] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        write_lim(32'h7FFF_FFFF);
        test_random(95);
        send_idle_pct = 48;
        write_lim(32'h8000_0000);
        test_random(95);
        send_idle_pct = 0;
        recv_stall_pct = 48;
        write_lim(32'h0010_0000);
        test_random(95);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        write_lim($urandom);
        test_random(95);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        wait_drained();
        repeat (2000) @(posedge aclk);
        if (errors == 0 && pending_dist.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
